// ----- hw/rtl/cbf_pkg.sv -----
`timescale 1ns / 1ps

package cbf_pkg;

	// physical ring storage and index widths
	localparam int DEPTH    = 256;
	localparam int RING_MAX = (DEPTH < 256) ? DEPTH : 256;
	localparam int IDX_W    = $clog2(RING_MAX);
	localparam int SIZE_W   = 9;
	localparam int BYTE_W   = 8;
	localparam int CNT_W    = 8;
	localparam int OVR_W    = 32;
	localparam int SIZE_RST = 256;

	// request operation codes
	typedef enum logic [1:0] {
		MODE_PUT = 2'd0,
		MODE_GET = 2'd1,
		MODE_CLR = 2'd2
	} mode_t;

	// response status codes
	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NODATA = 2'd2
	} status_t;

	// controller states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_FIN  = 1'b1
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic exec;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic rsp_busy;
	} sts_t;

endpackage

// ----- hw/rtl/cbf_if.sv -----
`timescale 1ns / 1ps

// request channel
interface cbf_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] put_byte;

	modport source (output valid, output mode, output put_byte, input ready);
	modport sink   (input valid, input mode, input put_byte, output ready);
endinterface

// response channel
interface cbf_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [7:0]  got_byte;
	logic [7:0]  count;
	logic [31:0] overrun_count;

	modport source (output valid, output status, output got_byte, output count,
		output overrun_count, input ready);
	modport sink   (input valid, input status, input got_byte, input count,
		input overrun_count, output ready);
endinterface

// size register write channel
interface cbf_cfg_if;
	logic       valid;
	logic       ready;
	logic [8:0] size_in_use;

	modport source (output valid, output size_in_use, input ready);
	modport sink   (input valid, input size_in_use, output ready);
endinterface

// ----- hw/rtl/cbf_ram.sv -----
`timescale 1ns / 1ps

module cbf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- hw/rtl/cbf_ctrl.sv -----
`timescale 1ns / 1ps

module cbf_ctrl
	import cbf_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   req_valid,
	input  sts_t   sts,
	output cmd_t   cmd,
	output logic   req_ready
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid && !sts.rsp_busy) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready  = 1'b0;
		cmd.exec   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = !sts.rsp_busy;
				cmd.exec  = req_valid && !sts.rsp_busy;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- hw/rtl/cbf_dp.sv -----
`timescale 1ns / 1ps

module cbf_dp
	import cbf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [1:0]        req_mode,
	input  logic [BYTE_W-1:0] req_put_byte,
	input  logic              cfg_wr,
	input  logic [SIZE_W-1:0] cfg_size,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output logic [1:0]        rsp_status,
	output logic [BYTE_W-1:0] rsp_got_byte,
	output logic [CNT_W-1:0]  rsp_count,
	output logic [OVR_W-1:0]  rsp_overrun_count
);

	logic [SIZE_W-1:0] size_q;
	logic [IDX_W-1:0]  rd_idx_q, wr_idx_q;
	logic [OVR_W-1:0]  ovr_q;
	status_t           status_q;
	logic              got_vld_q;
	logic              rsp_valid_q;
	logic [1:0]        rsp_status_q;
	logic [BYTE_W-1:0] rsp_got_q;
	logic [CNT_W-1:0]  rsp_count_q;
	logic [OVR_W-1:0]  rsp_ovr_q;

	logic [SIZE_W-1:0] ring_size;
	logic [SIZE_W-1:0] rd_ext, wr_ext, cnt;
	logic [SIZE_W-1:0] rd_inc, wr_inc;
	logic [IDX_W-1:0]  rd_next, wr_next;
	logic              full, empty;
	logic              ram_we, ram_re;
	logic [BYTE_W-1:0] ram_rdata;

	// size in effect, clamped to the usable range
	always_comb begin
		if (size_q < SIZE_W'(2)) begin
			ring_size = SIZE_W'(2);
		end else if (size_q > SIZE_W'(RING_MAX)) begin
			ring_size = SIZE_W'(RING_MAX);
		end else begin
			ring_size = size_q;
		end
	end

	// occupancy from the two indices
	assign rd_ext = {{(SIZE_W-IDX_W){1'b0}}, rd_idx_q};
	assign wr_ext = {{(SIZE_W-IDX_W){1'b0}}, wr_idx_q};
	assign cnt    = (rd_ext > wr_ext) ? (wr_ext + ring_size - rd_ext) : (wr_ext - rd_ext);
	assign full   = (cnt + SIZE_W'(1)) >= ring_size;
	assign empty  = (rd_idx_q == wr_idx_q);

	// index advance with wrap at the size in effect
	assign rd_inc  = rd_ext + SIZE_W'(1);
	assign wr_inc  = wr_ext + SIZE_W'(1);
	assign rd_next = (rd_inc >= ring_size) ? '0 : rd_inc[IDX_W-1:0];
	assign wr_next = (wr_inc >= ring_size) ? '0 : wr_inc[IDX_W-1:0];

	assign ram_we = cmd.exec && (req_mode == MODE_PUT) && !full;
	assign ram_re = cmd.exec && (req_mode == MODE_GET) && !empty;

	cbf_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (RING_MAX)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (wr_idx_q),
		.wr_data (req_put_byte),
		.rd_en   (ram_re),
		.rd_addr (rd_idx_q),
		.rd_data (ram_rdata)
	);

	// ring state: size, indices, overrun counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= SIZE_W'(SIZE_RST);
			rd_idx_q <= '0;
			wr_idx_q <= '0;
			ovr_q    <= '0;
		end else if (cfg_wr) begin
			size_q   <= cfg_size;
			rd_idx_q <= '0;
			wr_idx_q <= '0;
		end else if (cmd.exec) begin
			case (req_mode)
				MODE_PUT: begin
					if (full) begin
						ovr_q <= ovr_q + OVR_W'(1);
					end else begin
						wr_idx_q <= wr_next;
					end
				end
				MODE_GET: begin
					if (!empty) begin
						rd_idx_q <= rd_next;
					end
				end
				MODE_CLR: begin
					rd_idx_q <= '0;
					wr_idx_q <= '0;
					ovr_q    <= '0;
				end
				default: begin
					ovr_q <= ovr_q;
				end
			endcase
		end
	end

	// per-request outcome held until the result is built
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			got_vld_q <= ram_re;
			if ((req_mode == MODE_PUT) && full) begin
				status_q <= ST_FULL;
			end else if ((req_mode == MODE_GET) && empty) begin
				status_q <= ST_NODATA;
			end else begin
				status_q <= ST_OK;
			end
		end
	end

	// response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// response payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp_status_q <= status_q;
			rsp_got_q    <= got_vld_q ? ram_rdata : '0;
			rsp_count_q  <= cnt[CNT_W-1:0];
			rsp_ovr_q    <= ovr_q;
		end
	end

	assign sts.rsp_busy     = rsp_valid_q && !rsp_ready;
	assign rsp_valid        = rsp_valid_q;
	assign rsp_status       = rsp_status_q;
	assign rsp_got_byte     = rsp_got_q;
	assign rsp_count        = rsp_count_q;
	assign rsp_overrun_count = rsp_ovr_q;

endmodule

// ----- hw/rtl/circular_byte_fifo.sv -----
`timescale 1ns / 1ps

// circular_byte_fifo: byte ring buffer with a run-time size
//
// req channel: one request per operation, mode put, get or clear, with the
// byte to store on a put. rsp channel: one result per request with status
// (ok, full, no data), the byte taken on a get, the bytes waiting and the
// refused-put count since the last clear. cfg channel: writes the ring size
// (clamped to 2..256); a write empties the ring and keeps the overrun count.
// Write it only while no request is in flight. cfg.ready is always high.
//
// A request is accepted in the idle state, where the ring memory's registered
// read and the outcome are captured; the finish state then loads the result
// into the output register, where it stays valid until it is taken. A new
// request is accepted only once the previous result has been loaded.
// A new request is taken while a result waits, as long as that result is
// taken in the same cycle or the output register is empty.
// If the receiver stalls, the result holds and req.ready drops.
// Reset empties the ring, zeroes the overrun count and sets size to 256.
module circular_byte_fifo
	import cbf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	cbf_req_if.sink   req,
	cbf_rsp_if.source rsp,
	cbf_cfg_if.sink   cfg
);

	cmd_t cmd;
	sts_t sts;

	assign cfg.ready = 1'b1;

	// sequencing
	cbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.sts       (sts),
		.cmd       (cmd),
		.req_ready (req.ready)
	);

	// ring state, memory and output register
	cbf_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.req_mode          (req.mode),
		.req_put_byte      (req.put_byte),
		.cfg_wr            (cfg.valid),
		.cfg_size          (cfg.size_in_use),
		.rsp_valid         (rsp.valid),
		.rsp_ready         (rsp.ready),
		.rsp_status        (rsp.status),
		.rsp_got_byte      (rsp.got_byte),
		.rsp_count         (rsp.count),
		.rsp_overrun_count (rsp.overrun_count)
	);

endmodule

// ----- hw/rtl/cbf_checker.sv -----
`timescale 1ns / 1ps

module cbf_checker
	import cbf_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_status,
	input logic [7:0]  rsp_got_byte,
	input logic [7:0]  rsp_count,
	input logic [31:0] rsp_overrun_count
);

	// a stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_got_byte) && $stable(rsp_count)
			&& $stable(rsp_overrun_count))
		else $error("rsp payload changed while stalled");

	// one request in flight: no accept in the cycle after one
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in flight");

	// every accepted request yields a result once the finish state loads it
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |-> ##2 rsp_valid)
		else $error("result missing after accepted request");

	// a no-data get reports an empty ring and no byte
	a_nodata: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_NODATA) |-> (rsp_count == 8'd0)
			&& (rsp_got_byte == 8'd0))
		else $error("no-data result with bytes waiting");

	// only defined status codes, and no byte unless ok
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> (rsp_got_byte == 8'd0)
			&& ((rsp_status == ST_FULL) || (rsp_status == ST_NODATA)))
		else $error("bad status or byte on failed request");

endmodule

bind circular_byte_fifo cbf_checker u_cbf_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_got_byte      (rsp.got_byte),
	.rsp_count         (rsp.count),
	.rsp_overrun_count (rsp.overrun_count)
);
